### rtl/core/gdad_pkg.sv
// Shared types, constants and the calendar function of the date adder.
package gdad_pkg;

  localparam int YEAR_BITS_DEF   = 16;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int REM_W   = 9;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [REM_W-1:0]   CYCLE_YEARS = 9'd400;
  localparam logic [REM_W-1:0]   CENTURY_1   = 9'd100;
  localparam logic [REM_W-1:0]   CENTURY_2   = 9'd200;
  localparam logic [REM_W-1:0]   CENTURY_3   = 9'd300;

  localparam logic [DAY_W-1:0] LEN_LEAP_FEB = 5'd29;
  localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
  localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;
  localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mod_step;
    logic month_step;
  } gdad_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_last;
    logic day_over;
  } gdad_status_t;

  // Length of a month; codes outside 1..12 count as 31-day months.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MONTH_FEB: len = leap ? LEN_LEAP_FEB : LEN_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
      default: len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

### rtl/core/gdad_ctrl.sv
// Controller state machine of the date adder.
module gdad_ctrl
  import gdad_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_fire,
  input  logic         out_fire,
  input  gdad_status_t status,
  output gdad_cmd_t    cmd,
  output logic         idle,
  output logic         done
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MOD  = 4'b0010,
    ST_STEP = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd.load       = 1'b0;
    cmd.mod_step   = 1'b0;
    cmd.month_step = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_last) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status.day_over) begin
          cmd.month_step = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_DONE);

endmodule

### rtl/core/gdad_dp.sv
// Datapath of the date adder: date registers, year remainder unit and month step.
module gdad_dp
  import gdad_pkg::*;
#(
  parameter int YEAR_BITS   = YEAR_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk,
  input  gdad_cmd_t              cmd,
  input  logic [DAY_W-1:0]       start_day,
  input  logic [MONTH_W-1:0]     start_month,
  input  logic [YEAR_BITS-1:0]   start_year,
  input  logic [OFFSET_BITS-1:0] days_to_add,
  output gdad_status_t           status,
  output logic [DAY_W-1:0]       result_day,
  output logic [MONTH_W-1:0]     result_month,
  output logic [YEAR_BITS-1:0]   result_year,
  output logic                   year_overflow
);

  localparam int ACC_W = OFFSET_BITS + 1;

  // Year modulo 400 is 16 * ((year >> 4) mod 25) + (year mod 16). The quotient
  // by 25 comes from a reciprocal multiplication that is exact over the field.
  localparam int YEAR_Q = 25;
  localparam int HI_W   = YEAR_BITS - 4;
  localparam int MOD_W  = REM_W - 4;
  localparam int SHIFT  = HI_W + 5;
  localparam int PROD_W = 2 * HI_W + 1;
  localparam int QUO_W  = PROD_W - SHIFT;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'(YEAR_Q - 1)) / 64'(YEAR_Q);

  logic [ACC_W-1:0]     day;
  logic [MONTH_W-1:0]   month;
  logic [YEAR_BITS-1:0] year;
  logic                 ovf;
  logic [REM_W-1:0]     rem;       // year modulo 400
  logic [QUO_W-1:0]     quo;       // (year >> 4) divided by 25
  logic                 mod_phase;

  logic [HI_W-1:0]      year_hi;
  logic [QUO_W-1:0]     quo_next;
  logic [MOD_W-1:0]     hi_rem;
  logic                 leap;
  logic [DAY_W-1:0]     len;

  assign year_hi  = year[YEAR_BITS-1:4];
  assign quo_next = QUO_W'((PROD_W'(year_hi) * PROD_W'(RECIP)) >> SHIFT);
  assign hi_rem   = MOD_W'(year_hi - HI_W'(quo) * HI_W'(YEAR_Q));

  assign leap = ((year[1:0] == 2'b00) && (rem != CENTURY_1) && (rem != CENTURY_2)
                 && (rem != CENTURY_3)) || (rem == '0);
  assign len  = month_len(month, leap);

  assign status.day_over = (day > ACC_W'(len));
  assign status.mod_last = mod_phase;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day       <= ACC_W'(start_day) + ACC_W'(days_to_add);
      month     <= start_month;
      year      <= start_year;
      ovf       <= 1'b0;
      rem       <= '0;
      mod_phase <= 1'b0;
    end else if (cmd.mod_step) begin
      if (!mod_phase) begin
        quo       <= quo_next;
        mod_phase <= 1'b1;
      end else begin
        rem <= {hi_rem, year[3:0]};
      end
    end else if (cmd.month_step) begin
      day <= day - ACC_W'(len);
      if (month >= MONTH_DEC) begin
        month <= MONTH_JAN;
        if (year == '1) begin
          year <= '0;
          rem  <= '0;
          ovf  <= 1'b1;
        end else begin
          year <= year + 1'b1;
          rem  <= (rem == CYCLE_YEARS - 1'b1) ? '0 : rem + 1'b1;
        end
      end else begin
        month <= month + 1'b1;
      end
    end
  end

  assign result_day    = day[DAY_W-1:0];
  assign result_month  = month;
  assign result_year   = year;
  assign year_overflow = ovf;

endmodule

### rtl/core/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: stream ports, controller and datapath.
//
// This block advances a Gregorian date (day, month, year) by an unsigned
// number of days and returns the resulting date with a flag that tells
// whether the year wrapped past its largest value. One input transfer gives
// exactly one output transfer, and the block works on one date at a time:
// s_tready is high only while the block is idle. An item is loaded, then
// a reciprocal multiplication and a remainder step form the start year
// modulo 400 for the leap rule, then the month step loop steps once per
// month crossed and makes one final check, after which the result is held
// until it is taken. Start month codes outside 1..12 count as 31-day
// months, and a day of zero with a zero offset comes back unchanged.
module gregorian_date_add_days
  import gdad_pkg::*;
#(
  parameter int YEAR_BITS   = YEAR_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // From bit 0 up: start_day, start_month, start_year, days_to_add, zero fill.
  input  logic [((DAY_W + MONTH_W + YEAR_BITS + OFFSET_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // From bit 0 up: result_day, result_month, result_year, year_overflow, zero fill.
  output logic [((DAY_W + MONTH_W + YEAR_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int IN_USED  = DAY_W + MONTH_W + YEAR_BITS + OFFSET_BITS;
  localparam int OUT_USED = DAY_W + MONTH_W + YEAR_BITS + 1;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

  gdad_cmd_t    cmd;
  gdad_status_t status;
  logic         idle;
  logic         done;

  logic [DAY_W-1:0]     result_day;
  logic [MONTH_W-1:0]   result_month;
  logic [YEAR_BITS-1:0] result_year;
  logic                 year_overflow;

  logic in_fire;
  logic out_fire;

  assign s_tready = idle;
  assign m_tvalid = done;
  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;

  gdad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_fire (out_fire),
    .status   (status),
    .cmd      (cmd),
    .idle     (idle),
    .done     (done)
  );

  gdad_dp #(
    .YEAR_BITS   (YEAR_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .start_day     (s_tdata[DAY_W-1:0]),
    .start_month   (s_tdata[DAY_W +: MONTH_W]),
    .start_year    (s_tdata[DAY_W + MONTH_W +: YEAR_BITS]),
    .days_to_add   (s_tdata[IN_USED - OFFSET_BITS +: OFFSET_BITS]),
    .status        (status),
    .result_day    (result_day),
    .result_month  (result_month),
    .result_year   (result_year),
    .year_overflow (year_overflow)
  );

  // The datapath registers hold the finished date while the result waits.
  assign m_tdata = OUT_W'({year_overflow, result_year, result_month, result_day});

endmodule

### rtl/core/gdad_checker.sv
// Port-level checker of the date adder and its bind to the top level.
module gdad_checker #(
  parameter int OUT_W = 32
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // Once a date is taken in, the input is no longer ready.
  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again right after a transfer");

  // A waiting result and a free input never show together.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input ready while a result waits");

  // A result is delivered once.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> !m_tvalid && s_tready)
    else $error("result repeated or block not idle after delivery");

  // A stalled result holds its value.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind gregorian_date_add_days gdad_checker #(.OUT_W(OUT_W)) u_gdad_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### sim/date_add_checker.sv
// Checker for the date adder: predicts each result and compares it with the output stream.
module date_add_checker
  import gdad_pkg::*;
#(
  parameter int YEAR_BITS   = YEAR_BITS_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  // From bit 0 up: start_day, start_month, start_year, days_to_add, zero fill.
  input  logic [((DAY_W + MONTH_W + YEAR_BITS + OFFSET_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // From bit 0 up: result_day, result_month, result_year, year_overflow, zero fill.
  input  logic [((DAY_W + MONTH_W + YEAR_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  output int                   mismatches,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_BITS-1:0] year;
    logic                 wrapped;
  } calendar_date_t;

  calendar_date_t expected_dates[$];

  function automatic logic is_leap(input logic [YEAR_BITS-1:0] yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  // Month codes outside 1..12 are treated as 31-day months.
  function automatic int unsigned days_in_month(input logic [MONTH_W-1:0] mon,
                                                input logic [YEAR_BITS-1:0] yr);
    int unsigned len;
    if (mon == MONTH_FEB) begin
      len = is_leap(yr) ? 29 : 28;
    end else if (mon == MONTH_APR || mon == MONTH_JUN || mon == MONTH_SEP ||
                 mon == MONTH_NOV) begin
      len = 30;
    end else begin
      len = 31;
    end
    return len;
  endfunction

  // Walks month by month; the leap rule always sees the wrapped year.
  function automatic calendar_date_t advance_date(input logic [DAY_W-1:0] day,
                                                  input logic [MONTH_W-1:0] mon,
                                                  input logic [YEAR_BITS-1:0] yr,
                                                  input logic [OFFSET_BITS-1:0] offset);
    longint unsigned day_left;
    calendar_date_t  res;
    day_left = longint'(day) + longint'(offset);
    res.wrapped = 1'b0;
    while (day_left > days_in_month(mon, yr)) begin
      day_left -= days_in_month(mon, yr);
      if (mon >= MONTH_DEC) begin
        mon = MONTH_JAN;
        if (yr == '1) res.wrapped = 1'b1;
        yr = yr + 1'b1;
      end else begin
        mon = mon + 1'b1;
      end
    end
    res.day   = day_left[DAY_W-1:0];
    res.month = mon;
    res.year  = yr;
    return res;
  endfunction

  task automatic check_field(input string name, input longint unsigned exp_val,
                             input longint unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    calendar_date_t exp_date;
    if (!rst) begin
      // Retire the output first so a same-edge input never pairs with it.
      if (m_tvalid && m_tready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          exp_date = expected_dates.pop_front();
          check_field("result_day", exp_date.day, m_tdata[4:0]);
          check_field("result_month", exp_date.month, m_tdata[8:5]);
          check_field("result_year", exp_date.year, m_tdata[9 +: YEAR_BITS]);
          check_field("year_overflow", exp_date.wrapped, m_tdata[9 + YEAR_BITS]);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_dates.push_back(advance_date(s_tdata[4:0], s_tdata[8:5],
                                              s_tdata[9 +: YEAR_BITS],
                                              s_tdata[9 + YEAR_BITS +: OFFSET_BITS]));
      end
      pending <= expected_dates.size();
    end
  end

endmodule

### sim/testbench.sv
// Top of the date adder testbench: clock, reset, stimulus, result consumer and verdict.
module testbench
  import gdad_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int YEAR_BITS   = YEAR_BITS_DEF;
  localparam int OFFSET_BITS = OFFSET_BITS_DEF;
  localparam int IN_W  = ((DAY_W + MONTH_W + YEAR_BITS + OFFSET_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((DAY_W + MONTH_W + YEAR_BITS + 1 + 7) / 8) * 8;
  localparam int RANDOM_DATES = 230;
  // The receiver stops taking results for this long once, so the block
  // holds its result and refuses new transfers while the sender keeps offering.
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int HOLD_OFF_AT     = 40;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  int               mismatches;
  int               pending;

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  gregorian_date_add_days #(
    .YEAR_BITS  (YEAR_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  date_add_checker #(
    .YEAR_BITS  (YEAR_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) checker_inst (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Sender side bursts: while this is set, dates go out back to back.
  bit send_steady = 1'b0;
  int dates_sent  = 0;

  // Offers one date after a random gap and returns at the falling edge that
  // follows its transfer. With no gap, tvalid simply stays high.
  task automatic send_date(input logic [DAY_W-1:0] day, input logic [MONTH_W-1:0] month,
                           input logic [YEAR_BITS-1:0] year,
                           input logic [OFFSET_BITS-1:0] offset);
    int              gap;
    logic [IN_W-1:0] word;
    if (dates_sent % 16 == 0) send_steady = ($urandom_range(0, 3) == 0);
    gap = send_steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    word = '0;
    word[4:0] = day;
    word[8:5] = month;
    word[9 +: YEAR_BITS] = year;
    word[9 + YEAR_BITS +: OFFSET_BITS] = offset;
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    dates_sent++;
  endtask

  // Stops offering and waits until every predicted result has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Result consumer. It draws a wait before each result, runs stretches with
  // no waits, and once holds off for a long time to back the block up.
  initial begin
    int  gap;
    int  taken;
    bit  steady;
    taken  = 0;
    steady = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      else gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      @(negedge clk);
      taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [DAY_W-1:0]       day;
    logic [MONTH_W-1:0]     month;
    logic [YEAR_BITS-1:0]   year;
    logic [OFFSET_BITS-1:0] offset;
    int                     pick;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed dates: field extremes, leap rules, wraps and the odd inputs.
    send_date(5'd1, MONTH_JAN, '0, '0);                 // nothing to do
    send_date(5'd0, 4'd5, 16'd2023, '0);               // day zero stays zero
    send_date(5'd0, MONTH_JAN, 16'd2023, 16'd31);      // day zero, lands on Jan 31
    send_date(5'd0, MONTH_JAN, 16'd2023, 16'd32);      // day zero, crosses into February
    send_date(5'd31, MONTH_APR, 16'd2023, '0);         // day past the end of a 30-day month
    send_date(5'd31, MONTH_FEB, 16'd2023, '0);         // day past the end of February
    send_date(5'd28, MONTH_FEB, 16'd2024, 16'd1);      // ordinary leap year
    send_date(5'd28, MONTH_FEB, 16'd2023, 16'd1);      // common year
    send_date(5'd28, MONTH_FEB, 16'd1900, 16'd1);      // century, not leap
    send_date(5'd28, MONTH_FEB, 16'd2000, 16'd1);      // divisible by 400, leap
    send_date(5'd28, MONTH_FEB, '0, 16'd1);            // year zero is leap
    send_date(5'd28, MONTH_FEB, YEAR_MAX, 16'd1);      // largest year is common
    send_date(5'd31, MONTH_DEC, 16'd1999, 16'd1);      // year rollover
    send_date(5'd31, MONTH_DEC, YEAR_MAX, 16'd1);      // year wraps to zero
    send_date(5'd7, 4'd0, 16'd500, '0);                // month zero returned as is
    send_date(5'd31, 4'd0, 16'd500, 16'd1);            // month zero steps to January
    send_date(5'd1, 4'd13, 16'd500, 16'd40);           // month 13 wraps to next January
    send_date(5'd9, 4'd15, 16'd500, '0);               // month 15 returned as is
    send_date(5'd31, 4'd14, YEAR_MAX, 16'd1);          // month 14 wraps the year
    send_date(5'd1, MONTH_JAN, '0, '1);                // largest offset
    send_date(5'd1, MONTH_JAN, 16'd65400, '1);         // largest offset with a wrap
    send_date('1, 4'd15, YEAR_MAX, '1);                // every field at its top
    send_date(5'd30, MONTH_NOV, 16'd2100, 16'd120);    // crosses the end of a non-leap century year
    drain_results();

    // Random dates, mostly well formed with short offsets; a few reach far.
    for (int n = 0; n < RANDOM_DATES; n++) begin
      day = ($urandom_range(0, 9) == 0) ? 5'd0 : DAY_W'($urandom_range(1, 31));
      if ($urandom_range(0, 9) == 0) begin
        month = MONTH_W'($urandom_range(12, 15));
        if (month == MONTH_DEC) month = '0;
      end else begin
        month = MONTH_W'($urandom_range(1, 12));
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) year = YEAR_BITS'($urandom_range(0, 65535));
      else if (pick < 8) year = YEAR_BITS'($urandom_range(0, 655) * 100 + $urandom_range(0, 4));
      else year = YEAR_MAX - YEAR_BITS'($urandom_range(0, 3));
      pick = $urandom_range(0, 19);
      if (pick < 17) offset = OFFSET_BITS'($urandom_range(0, 800));
      else if (pick < 19) offset = OFFSET_BITS'($urandom_range(0, 65535));
      else offset = OFFSET_BITS'($urandom_range(65000, 65535));
      send_date(day, month, year, offset);
      if (n == RANDOM_DATES / 2) drain_results();
    end

    drain_results();
    // Let a stray late result show up before the verdict.
    repeat (50) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, several times the slowest legal run.
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
